/* hw/rtl/sia_pkg.sv */
package sia_pkg;

    localparam int unsigned IdxWidth    = 7;
    localparam int unsigned StepWidth   = 15;
    localparam int unsigned SampleWidth = 16;

    localparam logic [IdxWidth-1:0] IdxMax = IdxWidth'(88);

    typedef logic signed [SampleWidth-1:0] sample_t;
    typedef logic [IdxWidth-1:0]           step_idx_t;
    typedef logic [StepWidth-1:0]          step_t;
    typedef logic [3:0]                    code_t;

    // standard ima step table, anything above the top entry reads as the top entry
    function automatic step_t step_lookup(input step_idx_t idx);
        step_t s;
        case (idx)
            7'd0:  s = 15'd7;
            7'd1:  s = 15'd8;
            7'd2:  s = 15'd9;
            7'd3:  s = 15'd10;
            7'd4:  s = 15'd11;
            7'd5:  s = 15'd12;
            7'd6:  s = 15'd13;
            7'd7:  s = 15'd14;
            7'd8:  s = 15'd16;
            7'd9:  s = 15'd17;
            7'd10: s = 15'd19;
            7'd11: s = 15'd21;
            7'd12: s = 15'd23;
            7'd13: s = 15'd25;
            7'd14: s = 15'd28;
            7'd15: s = 15'd31;
            7'd16: s = 15'd34;
            7'd17: s = 15'd37;
            7'd18: s = 15'd41;
            7'd19: s = 15'd45;
            7'd20: s = 15'd50;
            7'd21: s = 15'd55;
            7'd22: s = 15'd60;
            7'd23: s = 15'd66;
            7'd24: s = 15'd73;
            7'd25: s = 15'd80;
            7'd26: s = 15'd88;
            7'd27: s = 15'd97;
            7'd28: s = 15'd107;
            7'd29: s = 15'd118;
            7'd30: s = 15'd130;
            7'd31: s = 15'd143;
            7'd32: s = 15'd157;
            7'd33: s = 15'd173;
            7'd34: s = 15'd190;
            7'd35: s = 15'd209;
            7'd36: s = 15'd230;
            7'd37: s = 15'd253;
            7'd38: s = 15'd279;
            7'd39: s = 15'd307;
            7'd40: s = 15'd337;
            7'd41: s = 15'd371;
            7'd42: s = 15'd408;
            7'd43: s = 15'd449;
            7'd44: s = 15'd494;
            7'd45: s = 15'd544;
            7'd46: s = 15'd598;
            7'd47: s = 15'd658;
            7'd48: s = 15'd724;
            7'd49: s = 15'd796;
            7'd50: s = 15'd876;
            7'd51: s = 15'd963;
            7'd52: s = 15'd1060;
            7'd53: s = 15'd1166;
            7'd54: s = 15'd1282;
            7'd55: s = 15'd1411;
            7'd56: s = 15'd1552;
            7'd57: s = 15'd1707;
            7'd58: s = 15'd1878;
            7'd59: s = 15'd2066;
            7'd60: s = 15'd2272;
            7'd61: s = 15'd2499;
            7'd62: s = 15'd2749;
            7'd63: s = 15'd3024;
            7'd64: s = 15'd3327;
            7'd65: s = 15'd3660;
            7'd66: s = 15'd4026;
            7'd67: s = 15'd4428;
            7'd68: s = 15'd4871;
            7'd69: s = 15'd5358;
            7'd70: s = 15'd5894;
            7'd71: s = 15'd6484;
            7'd72: s = 15'd7132;
            7'd73: s = 15'd7845;
            7'd74: s = 15'd8630;
            7'd75: s = 15'd9493;
            7'd76: s = 15'd10442;
            7'd77: s = 15'd11487;
            7'd78: s = 15'd12635;
            7'd79: s = 15'd13899;
            7'd80: s = 15'd15289;
            7'd81: s = 15'd16818;
            7'd82: s = 15'd18500;
            7'd83: s = 15'd20350;
            7'd84: s = 15'd22385;
            7'd85: s = 15'd24623;
            7'd86: s = 15'd27086;
            7'd87: s = 15'd29794;
            default: s = 15'd32767;
        endcase
        return s;
    endfunction

    // index adjustment, the sign bit of the code plays no part
    function automatic logic signed [7:0] index_adjust(input code_t code);
        logic signed [7:0] a;
        case (code[2:0])
            3'd4:    a = 8'sd2;
            3'd5:    a = 8'sd4;
            3'd6:    a = 8'sd6;
            3'd7:    a = 8'sd8;
            default: a = -8'sd1;
        endcase
        return a;
    endfunction

endpackage

/* hw/rtl/sia_chan.sv */
module sia_chan
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             restart,
    input  sia_pkg::code_t   code,
    output sia_pkg::sample_t sample_next
);

    sia_pkg::sample_t   pred_reg;
    sia_pkg::step_idx_t idx_reg;

    sia_pkg::sample_t   pred_cur;
    sia_pkg::step_idx_t idx_cur;
    sia_pkg::step_idx_t idx_next;
    sia_pkg::step_t     step;
    logic [16:0]        delta;
    logic signed [17:0] base;
    logic signed [17:0] sum;
    logic signed [7:0]  idx_sum;

    // restart clears the state before this word is decoded
    assign pred_cur = restart ? '0 : pred_reg;
    assign idx_cur  = restart ? '0 : idx_reg;

    assign step = sia_pkg::step_lookup(idx_cur);

    always_comb
    begin
        delta = 17'({step >> 3});
        if (code[2])
        begin
            delta = delta + 17'(step);
        end
        if (code[1])
        begin
            delta = delta + 17'({step >> 1});
        end
        if (code[0])
        begin
            delta = delta + 17'({step >> 2});
        end
    end

    assign base = 18'(pred_cur);

    always_comb
    begin
        if (code[3])
        begin
            sum = base - $signed({1'b0, delta});
        end
        else
        begin
            sum = base + $signed({1'b0, delta});
        end

        if (sum > 18'sd32767)
        begin
            sample_next = 16'sh7fff;
        end
        else if (sum < -18'sd32768)
        begin
            sample_next = 16'sh8000;
        end
        else
        begin
            sample_next = sum[15:0];
        end
    end

    always_comb
    begin
        idx_sum = $signed({1'b0, idx_cur}) + sia_pkg::index_adjust(code);
        if (idx_sum < 8'sd0)
        begin
            idx_next = '0;
        end
        else if (idx_sum > $signed({1'b0, sia_pkg::IdxMax}))
        begin
            idx_next = sia_pkg::IdxMax;
        end
        else
        begin
            idx_next = idx_sum[6:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pred_reg <= '0;
            idx_reg  <= '0;
        end
        else if (adv)
        begin
            pred_reg <= sample_next;
            idx_reg  <= idx_next;
        end
    end

endmodule

/* hw/rtl/stereo_ima_adpcm_decoder.sv */
// channel  direction  handshake             payload
// input    in         in_valid / in_ready   packed_codes[7:0], restart_state, block_end
// output   out        out_valid / out_ready left_sample[15:0], right_sample[15:0], block_end_out
//
// one word per cycle while out_ready is high; an accepted word passes the input register,
// the decode of both channels and the result register, which raises out_valid;
// the predictor and step index feedback is combinational up to the channel registers
// reset clears predictors, step indices and both valid flags
// a stalled output holds the result and the pending input word; ready falls only then
module stereo_ima_adpcm_decoder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  packed_codes,
    input  logic        restart_state,
    input  logic        block_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic signed [15:0] left_sample,
    output logic signed [15:0] right_sample,
    output logic        block_end_out
);

    logic       in_valid_reg;
    logic [7:0] codes_reg;
    logic       restart_reg;
    logic       bend_reg;

    logic             out_valid_reg;
    sia_pkg::sample_t left_reg;
    sia_pkg::sample_t right_reg;
    logic             bend_out_reg;

    sia_pkg::sample_t left_next;
    sia_pkg::sample_t right_next;
    logic             adv;

    // decode fires when a word is held and the result register can take it
    assign adv      = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            codes_reg   <= packed_codes;
            restart_reg <= restart_state;
            bend_reg    <= block_end;
        end
    end

    sia_chan u_left
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .restart     (restart_reg),
        .code        (codes_reg[3:0]),
        .sample_next (left_next)
    );

    sia_chan u_right
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .restart     (restart_reg),
        .code        (codes_reg[7:4]),
        .sample_next (right_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            left_reg     <= left_next;
            right_reg    <= right_next;
            bend_out_reg <= bend_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign left_sample   = left_reg;
    assign right_sample  = right_reg;
    assign block_end_out = bend_out_reg;

endmodule
